// ----- rtl/vesc_pkg.sv -----
`default_nettype none

package vesc_pkg;

   // decoder states, one-hot
   typedef enum logic [6:0] {
      ST_GROUND = 7'b000_0001,
      ST_START  = 7'b000_0010,
      ST_META   = 7'b000_0100,
      ST_META1  = 7'b000_1000,
      ST_CTRL   = 7'b001_0000,
      ST_OCT2   = 7'b010_0000,
      ST_OCT3   = 7'b100_0000
   } dec_state_type;

   // input kinds (carried on req_tuser)
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   // result status (carried on rsp_tuser)
   localparam logic STAT_OK  = 1'b0;
   localparam logic STAT_BAD = 1'b1;

   // one result beat
   typedef struct packed {
      logic [7:0] ch;
      logic       status;
      logic       last;
   } rsp_item_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // character codes
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_M      = 8'h4D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_A      = 8'h61;
   localparam logic [7:0] CH_V      = 8'h76;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_S      = 8'h73;
   localparam logic [7:0] CH_E      = 8'h45;
   localparam logic [7:0] CH_QMARK  = 8'h3F;

   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_BEL    = 8'h07;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_ESC    = 8'h1B;

   localparam logic [7:0] META_BIT  = 8'h80;
   localparam logic [7:0] CTRL_MASK = 8'h1F;
   localparam logic [7:0] DEL_CODE  = 8'h7F;

   // '0'..'7' share upper bits 00110
   localparam logic [4:0] OCT_HIGH  = 5'b00110;

endpackage

`default_nettype wire

// ----- rtl/visual_escape_decoder.sv -----
`default_nettype none

// Each result beat is registered in the result queue when its request beat is taken.
// Throughput: one request beat per cycle while req_tready is high; a beat that ends an octal run
// with a plain byte yields two result beats, so the rsp_ side then drains one per cycle while rsp_tready is high.
// The four-entry result queue sets the stall point: req_tready drops at three held.
// Reset (synchronous, active high) returns the decoder to ground, clears the partial byte and empties the queue.
module visual_escape_decoder (
   input  var logic       clock,
   input  var logic       reset,

   // request stream
   input  var logic       req_tvalid,
   output logic           req_tready,
   input  var logic [7:0] req_tdata,   // [7:0] char_in
   input  var logic       req_tuser,   // [0] op (0 data, 1 end of string)

   // result stream
   output logic           rsp_tvalid,
   input  var logic       rsp_tready,
   output logic [7:0]     rsp_tdata,   // [7:0] char_out
   output logic           rsp_tuser,   // [0] status (1 bad escape)
   output logic           rsp_tlast    // final beat caused by one request beat
);

   vesc_pkg::dec_state_type state_ff, state_in, state_step;
   logic [7:0]              partial_ff, partial_in, partial_step;
   vesc_pkg::rsp_item_type  res0, res1, head;
   logic [1:0]              res_count, push_count;
   logic                    head_valid;
   logic                    room_for_two;
   logic                    req_beat;

   // Decode runs straight off the accepted beat; the queue is the result register.
   vesc_step u_step (
      .state        (state_ff),
      .partial      (partial_ff),
      .op           (req_tuser),
      .ch           (req_tdata),
      .state_next   (state_step),
      .partial_next (partial_step),
      .res0         (res0),
      .res1         (res1),
      .res_count    (res_count)
   );

   assign req_tready = room_for_two;
   assign req_beat   = req_tvalid && req_tready;
   assign push_count = req_beat ? res_count : 2'd0;

   always_comb begin
      state_in   = req_beat ? state_step   : state_ff;
      partial_in = req_beat ? partial_step : partial_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= vesc_pkg::ST_GROUND;
         partial_ff <= 8'h00;
      end else begin
         state_ff   <= state_in;
         partial_ff <= partial_in;
      end
   end

   // Holds up to four results; two free slots are kept for a worst-case beat.
   vesc_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push0        (res0),
      .push1        (res1),
      .head         (head),
      .head_valid   (head_valid),
      .pop          (rsp_tready),
      .room_for_two (room_for_two)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = head.ch;
   assign rsp_tuser  = head.status;
   assign rsp_tlast  = head.last;

endmodule

`default_nettype wire

// ----- rtl/vesc_step.sv -----
`default_nettype none

// One decode step: current state and beat in, next state and up to two results out.
module vesc_step (
   input  var vesc_pkg::dec_state_type state,
   input  var logic [7:0]              partial,
   input  var logic                    op,
   input  var logic [7:0]              ch,
   output vesc_pkg::dec_state_type     state_next,
   output logic [7:0]                  partial_next,
   output vesc_pkg::rsp_item_type      res0,
   output vesc_pkg::rsp_item_type      res1,
   output logic [1:0]                  res_count
);

   logic       is_oct;
   logic [7:0] oct_acc;
   logic [7:0] r0_ch;
   logic [7:0] r1_ch;
   logic       r0_st;
   logic [1:0] n;

   assign is_oct  = (ch[7:3] == vesc_pkg::OCT_HIGH);
   assign oct_acc = {partial[4:0], 3'b000} + {5'b00000, ch[2:0]};

   always_comb begin
      state_next   = state;
      partial_next = partial;
      r0_ch        = 8'h00;
      r0_st        = vesc_pkg::STAT_OK;
      r1_ch        = 8'h00;
      n            = 2'd0;

      if (op == vesc_pkg::OP_END) begin
         state_next = vesc_pkg::ST_GROUND;
         if (state == vesc_pkg::ST_OCT2 || state == vesc_pkg::ST_OCT3) begin
            r0_ch = partial;
            n     = 2'd1;
         end else if (state != vesc_pkg::ST_GROUND) begin
            r0_st = vesc_pkg::STAT_BAD;
            n     = 2'd1;
         end
      end else begin
         unique case (state)
            vesc_pkg::ST_GROUND: begin
               if (ch == vesc_pkg::CH_BSLASH) begin
                  partial_next = 8'h00;
                  state_next   = vesc_pkg::ST_START;
               end else begin
                  partial_next = ch;
                  r0_ch        = ch;
                  n            = 2'd1;
               end
            end
            vesc_pkg::ST_START: begin
               state_next = vesc_pkg::ST_GROUND;
               if (is_oct) begin
                  partial_next = {5'b00000, ch[2:0]};
                  state_next   = vesc_pkg::ST_OCT2;
               end else begin
                  unique case (ch) inside
                     vesc_pkg::CH_DASH: partial_next = 8'h00;
                     vesc_pkg::CH_NL, vesc_pkg::CH_DOLLAR: ;
                     vesc_pkg::CH_M: begin
                        partial_next = vesc_pkg::META_BIT;
                        state_next   = vesc_pkg::ST_META;
                     end
                     vesc_pkg::CH_CARET: state_next = vesc_pkg::ST_CTRL;
                     vesc_pkg::CH_BSLASH, vesc_pkg::CH_QUOTE: begin
                        partial_next = ch; r0_ch = ch; n = 2'd1;
                     end
                     vesc_pkg::CH_N: begin
                        partial_next = vesc_pkg::CH_NL; r0_ch = vesc_pkg::CH_NL; n = 2'd1;
                     end
                     vesc_pkg::CH_R: begin
                        partial_next = vesc_pkg::CH_CR; r0_ch = vesc_pkg::CH_CR; n = 2'd1;
                     end
                     vesc_pkg::CH_B: begin
                        partial_next = vesc_pkg::CH_BS; r0_ch = vesc_pkg::CH_BS; n = 2'd1;
                     end
                     vesc_pkg::CH_A: begin
                        partial_next = vesc_pkg::CH_BEL; r0_ch = vesc_pkg::CH_BEL; n = 2'd1;
                     end
                     vesc_pkg::CH_V: begin
                        partial_next = vesc_pkg::CH_VT; r0_ch = vesc_pkg::CH_VT; n = 2'd1;
                     end
                     vesc_pkg::CH_T: begin
                        partial_next = vesc_pkg::CH_TAB; r0_ch = vesc_pkg::CH_TAB; n = 2'd1;
                     end
                     vesc_pkg::CH_F: begin
                        partial_next = vesc_pkg::CH_FF; r0_ch = vesc_pkg::CH_FF; n = 2'd1;
                     end
                     vesc_pkg::CH_S: begin
                        partial_next = vesc_pkg::CH_SPACE; r0_ch = vesc_pkg::CH_SPACE;
                        n = 2'd1;
                     end
                     vesc_pkg::CH_E: begin
                        partial_next = vesc_pkg::CH_ESC; r0_ch = vesc_pkg::CH_ESC; n = 2'd1;
                     end
                     default: begin
                        r0_st = vesc_pkg::STAT_BAD;
                        n     = 2'd1;
                     end
                  endcase
               end
            end
            vesc_pkg::ST_META: begin
               if (ch == vesc_pkg::CH_DASH) begin
                  state_next = vesc_pkg::ST_META1;
               end else if (ch == vesc_pkg::CH_CARET) begin
                  state_next = vesc_pkg::ST_CTRL;
               end else begin
                  state_next = vesc_pkg::ST_GROUND;
                  r0_st      = vesc_pkg::STAT_BAD;
                  n          = 2'd1;
               end
            end
            vesc_pkg::ST_META1: begin
               state_next   = vesc_pkg::ST_GROUND;
               partial_next = partial | ch;
               r0_ch        = partial | ch;
               n            = 2'd1;
            end
            vesc_pkg::ST_CTRL: begin
               state_next = vesc_pkg::ST_GROUND;
               if (ch == vesc_pkg::CH_QMARK) begin
                  partial_next = partial | vesc_pkg::DEL_CODE;
               end else begin
                  partial_next = partial | (ch & vesc_pkg::CTRL_MASK);
               end
               r0_ch = partial_next;
               n     = 2'd1;
            end
            vesc_pkg::ST_OCT2, vesc_pkg::ST_OCT3: begin
               if (is_oct) begin
                  partial_next = oct_acc;
                  if (state == vesc_pkg::ST_OCT2) begin
                     state_next = vesc_pkg::ST_OCT3;
                  end else begin
                     state_next = vesc_pkg::ST_GROUND;
                     r0_ch      = oct_acc;
                     n          = 2'd1;
                  end
               end else begin
                  // flush the octal byte, then redo this beat from ground
                  r0_ch = partial;
                  if (ch == vesc_pkg::CH_BSLASH) begin
                     partial_next = 8'h00;
                     state_next   = vesc_pkg::ST_START;
                     n            = 2'd1;
                  end else begin
                     partial_next = ch;
                     state_next   = vesc_pkg::ST_GROUND;
                     r1_ch        = ch;
                     n            = 2'd2;
                  end
               end
            end
            default: begin
               state_next = vesc_pkg::ST_GROUND;
               r0_st      = vesc_pkg::STAT_BAD;
               n          = 2'd1;
            end
         endcase
      end
   end

   assign res0      = '{ch: r0_ch, status: r0_st, last: (n == 2'd1)};
   assign res1      = '{ch: r1_ch, status: vesc_pkg::STAT_OK, last: 1'b1};
   assign res_count = n;

endmodule

`default_nettype wire

// ----- rtl/vesc_queue.sv -----
`default_nettype none

// Small result queue: takes up to two entries per cycle, gives at most one.
module vesc_queue (
   input  var logic                   clock,
   input  var logic                   reset,
   input  var logic [1:0]             push_count,
   input  var vesc_pkg::rsp_item_type push0,
   input  var vesc_pkg::rsp_item_type push1,
   output vesc_pkg::rsp_item_type     head,
   output logic                       head_valid,
   input  var logic                   pop,
   output logic                       room_for_two
);

   localparam int PW = vesc_pkg::QUEUE_PTR_W;
   localparam int CW = vesc_pkg::QUEUE_CNT_W;

   vesc_pkg::rsp_item_type entry_ff [vesc_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, wr_next1;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_pop;

   assign do_pop   = pop && (cnt_ff != '0);
   assign wr_next1 = wr_ff + PW'(1);

   always_comb begin
      wr_in  = wr_ff + PW'(push_count);
      rd_in  = do_pop ? rd_ff + PW'(1) : rd_ff;
      cnt_in = cnt_ff + CW'(push_count) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_next1] <= push1;
      end
   end

   assign head         = entry_ff[rd_ff];
   assign head_valid   = (cnt_ff != '0);
   assign room_for_two = (cnt_ff <= CW'(vesc_pkg::QUEUE_DEPTH - 2));

endmodule

`default_nettype wire
